/* rtl/rle_pkg.sv */
package rle_pkg;

  localparam int unsigned SYM_W = 8;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned POW_W = 3;
  localparam int unsigned DIG_W = 4;

  localparam logic [SYM_W-1:0] ASCII_ZERO = 8'h30;
  localparam logic [SYM_W-1:0] TERM_BYTE  = 8'h00;

  // One closed run handed from the front to the back.
  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic [LEN_W-1:0] len;   // 0: no run, terminator only
    logic             term;  // string ends after this run
  } rle_job_t;

  typedef enum logic [1:0] {
    PH_DIGIT,
    PH_LIT,
    PH_TERM
  } rle_phase_t;

  // Emission context of the job in the back end.
  typedef struct packed {
    rle_phase_t       phase;
    logic [LEN_W-1:0] rem;    // count still to print as digits
    logic [POW_W-1:0] pow;    // decimal place of the next digit
    logic             extra;  // a second literal follows
    logic [SYM_W-1:0] sym;
    logic             term;
  } rle_ctx_t;

  function automatic logic [LEN_W:0] pow10(input logic [POW_W-1:0] p);
    logic [LEN_W:0] v;
    case (p)
      3'd0:    v = 17'd1;
      3'd1:    v = 17'd10;
      3'd2:    v = 17'd100;
      3'd3:    v = 17'd1000;
      3'd4:    v = 17'd10000;
      default: v = 17'd1;
    endcase
    return v;
  endfunction

  // Leading decimal digit of rem at place p; rem is below 10 * 10^p.
  // Each multiple of the place value is a constant multiple, compared in parallel.
  function automatic logic [DIG_W-1:0] lead_digit(input logic [LEN_W-1:0] rem,
                                                  input logic [POW_W-1:0] p);
    logic [DIG_W-1:0] d;
    logic [20:0]      step;
    logic [20:0]      acc;
    d    = '0;
    step = 21'(pow10(p));
    for (int j = 1; j <= 9; j++) begin
      acc = step * 21'(j);
      if ({5'd0, rem} >= acc) begin
        d = DIG_W'(j);
      end
    end
    return d;
  endfunction

  // Place of the most significant digit of a run length.
  function automatic logic [POW_W-1:0] top_place(input logic [LEN_W-1:0] len);
    logic [POW_W-1:0] p;
    if (len >= 16'd10000) begin
      p = 3'd4;
    end else if (len >= 16'd1000) begin
      p = 3'd3;
    end else if (len >= 16'd100) begin
      p = 3'd2;
    end else if (len >= 16'd10) begin
      p = 3'd1;
    end else begin
      p = 3'd0;
    end
    return p;
  endfunction

endpackage

/* rtl/rle_encoder_decimal_count.sv */
// Run-length packer for zero-terminated byte strings. One byte is taken per
// cycle on the in_ channel while in_stall is low; a run of one or two comes
// out as the literal byte once or twice, a longer run as its length in ASCII
// decimal digits (most significant first) followed by the byte, and a zero
// byte flushes the open run and then emits a zero terminator. Runs saturate
// at MAX_RUN. The front end tracks the open run and pushes each closed run
// into a QUEUE_DEPTH-entry job queue; the back end drains it at one output
// byte per cycle unless out_stall holds it, producing one decimal digit per
// cycle. A closed run takes 1 to 6 output bytes plus one for a terminator,
// and its first byte passes through the queue and then the output register.
// in_stall rises only while the job queue is full, i.e. when the output side
// is stalled or falls behind on runs with many digits.
module rle_encoder_decimal_count #(
  parameter int unsigned MAX_RUN     = 65535,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [rle_pkg::SYM_W-1:0] in_symbol,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rle_pkg::SYM_W-1:0] out_byte,
  output logic                      out_last_of_run
);
  import rle_pkg::*;

  rle_job_t push_job;
  rle_job_t head_job;
  logic     q_push;
  logic     q_pop;
  logic     q_empty;
  logic     q_full;

  rle_front #(
    .MAX_RUN (MAX_RUN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_symbol (in_symbol),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  rle_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  rle_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_job        (head_job),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule

/* rtl/rle_fifo.sv */
module rle_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rle_pkg::rle_job_t push_job,
  input  logic              pop,
  output rle_pkg::rle_job_t head_job,
  output logic              empty,
  output logic              full
);
  import rle_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  rle_job_t         slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign empty    = (cnt_r == '0);
  assign full     = (cnt_r == FULL_CNT);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

/* rtl/rle_front.sv */
module rle_front #(
  parameter int unsigned MAX_RUN = 65535
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rle_pkg::SYM_W-1:0]       in_symbol,
  input  logic                            q_full,
  output logic                            q_push,
  output rle_pkg::rle_job_t               q_job
);
  import rle_pkg::*;

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_RUN);

  logic [SYM_W-1:0] run_sym_r, run_sym_nxt;
  logic [LEN_W-1:0] run_len_r, run_len_nxt;
  logic             take;

  assign in_stall = q_full;
  assign take     = in_valid && !q_full;

  always_comb begin
    run_sym_nxt = run_sym_r;
    run_len_nxt = run_len_r;
    q_push      = 1'b0;
    q_job.sym   = run_sym_r;
    q_job.len   = run_len_r;
    q_job.term  = 1'b0;
    if (take) begin
      if (in_symbol == TERM_BYTE) begin
        // terminator flushes whatever is open
        q_push      = 1'b1;
        q_job.term  = 1'b1;
        run_sym_nxt = '0;
        run_len_nxt = '0;
      end else if (run_len_r != '0 && in_symbol == run_sym_r) begin
        if (run_len_r < MAX_LEN) begin
          run_len_nxt = run_len_r + 1'b1;
        end
      end else begin
        q_push      = (run_len_r != '0);
        run_sym_nxt = in_symbol;
        run_len_nxt = LEN_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sym_r <= '0;
      run_len_r <= '0;
    end else begin
      run_sym_r <= run_sym_nxt;
      run_len_r <= run_len_nxt;
    end
  end

endmodule

/* rtl/rle_back.sv */
module rle_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rle_pkg::rle_job_t         head_job,
  input  logic                      q_empty,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [rle_pkg::SYM_W-1:0] out_byte,
  output logic                      out_last_of_run
);
  import rle_pkg::*;

  rle_ctx_t         ctx_r, ctx_nxt;
  rle_ctx_t         cur;
  logic             busy_r, busy_nxt;
  logic             out_valid_r;
  logic [SYM_W-1:0] out_byte_r;
  logic             out_last_r;
  logic             have;
  logic             adv;
  logic             emit;
  logic [SYM_W-1:0] emit_byte;
  logic             emit_last;
  logic [DIG_W-1:0] dig;

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

  assign adv   = !out_valid_r || !out_stall;
  assign have  = busy_r || !q_empty;
  assign emit  = adv && have;
  assign q_pop = adv && !busy_r && !q_empty;

  // Saved context while busy, else a fresh one from the queue head.
  always_comb begin
    if (busy_r) begin
      cur = ctx_r;
    end else begin
      cur.sym   = head_job.sym;
      cur.term  = head_job.term;
      cur.rem   = head_job.len;
      cur.pow   = top_place(head_job.len);
      cur.extra = (head_job.len == LEN_W'(2));
      if (head_job.len == '0) begin
        cur.phase = PH_TERM;
      end else if (head_job.len < LEN_W'(3)) begin
        cur.phase = PH_LIT;
      end else begin
        cur.phase = PH_DIGIT;
      end
    end
  end

  assign dig = lead_digit(cur.rem, cur.pow);

  // byte out of the current context
  always_comb begin
    emit_byte = TERM_BYTE;
    emit_last = 1'b0;
    case (cur.phase)
      PH_DIGIT: begin
        emit_byte = ASCII_ZERO + SYM_W'(dig);
      end
      PH_LIT: begin
        emit_byte = cur.sym;
        emit_last = !cur.extra && !cur.term;
      end
      PH_TERM: begin
        emit_byte = TERM_BYTE;
        emit_last = 1'b1;
      end
      default: begin
        emit_byte = TERM_BYTE;
        emit_last = 1'b1;
      end
    endcase
  end

  // context after that byte
  always_comb begin
    ctx_nxt  = cur;
    busy_nxt = busy_r;
    if (emit) begin
      busy_nxt = !emit_last;
      case (cur.phase)
        PH_DIGIT: begin
          ctx_nxt.rem = cur.rem - LEN_W'(pow10(cur.pow) * (LEN_W + 1)'(dig));
          if (cur.pow == '0) begin
            ctx_nxt.phase = PH_LIT;
          end else begin
            ctx_nxt.pow = cur.pow - 1'b1;
          end
        end
        PH_LIT: begin
          if (cur.extra) begin
            ctx_nxt.extra = 1'b0;
          end else begin
            ctx_nxt.phase = PH_TERM;
          end
        end
        PH_TERM: begin
          ctx_nxt.phase = PH_TERM;
        end
        default: begin
          busy_nxt = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      if (adv) begin
        out_valid_r <= have;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ctx_r      <= ctx_nxt;
      out_byte_r <= emit_byte;
      out_last_r <= emit_last;
    end
  end

endmodule
